// ===== src/assert_macros.svh =====
// Assertion macros shared by the modular power core RTL.
// Needs a clk_i clock and an active-low rst_ni reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define MPI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define MPI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/mpi_pkg.sv =====
// Shared types and codes for the modular power and inverse core.
// No dependencies.
`default_nettype none

package mpi_pkg;

  // Action codes carried by each request
  localparam logic ActPower   = 1'b0;
  localparam logic ActInverse = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_REDUCE  = 5'b00010,
    ST_MUL_DBL = 5'b00100,
    ST_MUL_ADD = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== src/modular_power_and_inverse_core.sv =====
// Modular exponentiation / Fermat inverse core, one shared modular adder under a sequencer.
// Depends on mpi_pkg and assert_macros.svh.
//
//   channel | signals                                   | direction | handshake
//   --------+-------------------------------------------+-----------+---------------------
//   input   | action_i, base_value_i, exponent_i        | in        | in_valid_i/in_stall_o
//   output  | result_o                                  | out       | out_valid_o/out_stall_i
//   config  | cfg_modulus_i                             | in        | cfg_valid_i/cfg_ready_o
//
// Per request (W = WORD_BITS): the base is reduced first, then for each of the W exponent
// bits a modular square, plus a modular multiply when the bit is set; a modular multiply
// takes one doubling step per multiplier bit plus one add step per set bit of its multiplier,
// all on the one modular adder. A modulus below two goes straight to the finish with result zero.
// Reset loads the modulus with 1000000007 (truncated to W bits) and empties the output.
// A stalled result waits in the output register while the next request is already taken.
`default_nettype none
`include "assert_macros.svh"

module modular_power_and_inverse_core #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic signed [WORD_BITS-1:0] base_value_i,
  input  logic        [WORD_BITS-1:0] exponent_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic        [WORD_BITS-1:0] result_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic        [WORD_BITS-1:0] cfg_modulus_i
);

  import mpi_pkg::*;

  localparam int CntW = $clog2(WORD_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] ModulusReset = WORD_BITS'(64'd1000000007);

  state_e state_q, state_d;
  logic [WORD_BITS-1:0] modulus_q;
  logic [WORD_BITS-1:0] macc_q, macc_d;       // running sum / remainder
  logic [WORD_BITS-1:0] mcand_q, mcand_d;     // power accumulator, also the addend
  logic [WORD_BITS-1:0] mplier_q, mplier_d;   // multiplier bits, scanned from the top
  logic [WORD_BITS-1:0] base_q, base_d;       // reduced base
  logic [WORD_BITS-1:0] exp_q, exp_d;         // exponent bits, scanned from the top
  logic [WORD_BITS-1:0] result_q, result_d;
  logic [CntW-1:0]      bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0]      exp_cnt_q, exp_cnt_d;
  logic                 mult_phase_q, mult_phase_d;
  logic                 neg_q, neg_d;
  logic                 out_valid_q, out_valid_d;

  // Shared modular adder: (a + b + cin) mod m for a, b < m
  logic [WORD_BITS-1:0] unit_b;
  logic                 unit_cin;
  logic [WORD_BITS:0]   unit_sum;
  logic [WORD_BITS:0]   unit_diff;
  logic [WORD_BITS-1:0] unit_res;

  assign unit_b    = (state_q == ST_MUL_ADD) ? mcand_q : macc_q;
  assign unit_cin  = (state_q == ST_REDUCE) ? mplier_q[WORD_BITS-1] : 1'b0;
  assign unit_sum  = {1'b0, macc_q} + {1'b0, unit_b} + {{WORD_BITS{1'b0}}, unit_cin};
  assign unit_diff = unit_sum - {1'b0, modulus_q};
  assign unit_res  = (unit_sum >= {1'b0, modulus_q}) ? unit_diff[WORD_BITS-1:0]
                                                    : unit_sum[WORD_BITS-1:0];

  // Sequencer
  logic                 mul_last;
  logic [WORD_BITS-1:0] base_u;

  assign base_u = base_value_i;

  always_comb begin
    state_d      = state_q;
    macc_d       = macc_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    base_d       = base_q;
    exp_d        = exp_q;
    result_d     = result_q;
    bit_cnt_d    = bit_cnt_q;
    exp_cnt_d    = exp_cnt_q;
    mult_phase_d = mult_phase_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mul_last     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          neg_d     = base_u[WORD_BITS-1];
          mplier_d  = base_u[WORD_BITS-1] ? (~base_u + 1'b1) : base_u;
          macc_d    = '0;
          bit_cnt_d = CntLast;
          exp_d     = (action_i == ActInverse) ? (modulus_q - WORD_BITS'(2)) : exponent_i;
          if (modulus_q < WORD_BITS'(2)) begin
            mcand_d = '0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // shift one magnitude bit into the remainder per cycle
        macc_d    = unit_res;
        mplier_d  = mplier_q << 1;
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          base_d       = (neg_q && (unit_res != '0)) ? (modulus_q - unit_res) : unit_res;
          mcand_d      = WORD_BITS'(1);
          mplier_d     = WORD_BITS'(1);
          macc_d       = '0;
          bit_cnt_d    = CntLast;
          exp_cnt_d    = CntLast;
          mult_phase_d = 1'b0;
          state_d      = ST_MUL_DBL;
        end
      end
      ST_MUL_DBL: begin
        macc_d = unit_res;
        if (mplier_q[WORD_BITS-1]) begin
          state_d = ST_MUL_ADD;
        end else begin
          mplier_d  = mplier_q << 1;
          bit_cnt_d = bit_cnt_q - 1'b1;
          mul_last  = (bit_cnt_q == '0);
        end
      end
      ST_MUL_ADD: begin
        macc_d    = unit_res;
        mplier_d  = mplier_q << 1;
        bit_cnt_d = bit_cnt_q - 1'b1;
        mul_last  = (bit_cnt_q == '0);
        state_d   = ST_MUL_DBL;
      end
      ST_FINISH: begin
        // hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          result_d    = mcand_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // End of a modular product: square next, multiply by the base, or finish
    if (mul_last) begin
      mcand_d   = unit_res;
      macc_d    = '0;
      bit_cnt_d = CntLast;
      if (!mult_phase_q && exp_q[WORD_BITS-1]) begin
        mult_phase_d = 1'b1;
        mplier_d     = base_q;
        state_d      = ST_MUL_DBL;
      end else begin
        mult_phase_d = 1'b0;
        exp_d        = exp_q << 1;
        mplier_d     = unit_res;
        exp_cnt_d    = exp_cnt_q - 1'b1;
        state_d      = (exp_cnt_q == '0) ? ST_FINISH : ST_MUL_DBL;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      bit_cnt_q    <= '0;
      exp_cnt_q    <= '0;
      mult_phase_q <= 1'b0;
      modulus_q    <= ModulusReset;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      bit_cnt_q    <= bit_cnt_d;
      exp_cnt_q    <= exp_cnt_d;
      mult_phase_q <= mult_phase_d;
      if (cfg_valid_i && cfg_ready_o) begin
        modulus_q <= cfg_modulus_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    macc_q   <= macc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    base_q   <= base_d;
    exp_q    <= exp_d;
    result_q <= result_d;
    neg_q    <= neg_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // Checks
  `MPI_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "core idle after accepting a request")
  `MPI_ASSERT(a_operands_reduced, (state_q == ST_MUL_DBL || state_q == ST_MUL_ADD) |-> (macc_q < modulus_q && mcand_q < modulus_q && base_q < modulus_q), "modular operand not below the modulus")
  `MPI_ASSERT(a_finish_delivers, (state_q == ST_FINISH && !(out_valid_q && out_stall_i)) |=> (out_valid_o && state_q == ST_IDLE), "finished result not presented")
  `MPI_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q) || !rst_ni, "sequencer state not one-hot")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for modular_power_and_inverse_core: power and Fermat-inverse requests
// under several moduli, with a square-and-multiply predictor and random idling on both sides.
// Depends on mpi_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpi_pkg::*;

  localparam int W = 32;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int TAIL_CYCLES = 4200;
  localparam int RANDOM_PHASES = 8;
  localparam int PER_PHASE = 33;
  localparam int DIRECTED_ROWS = 22;

  localparam logic signed [W-1:0] BASE_MIN = 32'sh8000_0000;
  localparam logic signed [W-1:0] BASE_MAX = 32'sh7fff_ffff;
  localparam logic [W-1:0] EXP_ONES = 32'hffff_ffff;
  localparam logic [W-1:0] MOD_RESET = 32'd1000000007;
  localparam logic [W-1:0] MOD_TOP = 32'hffff_ffff;
  localparam logic [W-1:0] PRIME_TOP = 32'd4294967291;

  typedef struct {
    logic                set_mod;
    logic [W-1:0]        modv;
    logic                act;
    logic signed [W-1:0] base;
    logic [W-1:0]        expo;
    logic                known;
    logic [W-1:0]        want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                action_i = ActPower;
  logic signed [W-1:0] base_value_i = '0;
  logic [W-1:0]        exponent_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [W-1:0]        result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [W-1:0]        cfg_modulus_i = '0;

  logic [W-1:0] expected_results[$];
  logic [W-1:0] cur_modulus = MOD_RESET;
  logic [W-1:0] oldest_result;
  int           errors = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  bit           stall_on = 1'b1;
  bit           quiet_tail = 1'b0;

  modular_power_and_inverse_core #(
    .WORD_BITS(W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .base_value_i (base_value_i),
    .exponent_i   (exponent_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_modulus_i(cfg_modulus_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Compute base^exponent mod modulus (exponent modulus - 2 for an inverse), right-to-left over the exponent bits
  function automatic logic [W-1:0] predict_power(logic act, logic signed [W-1:0] base,
                                                 logic [W-1:0] expo, logic [W-1:0] modv);
    longint unsigned m;
    longint unsigned e;
    longint unsigned b;
    longint unsigned acc;
    longint          sb;
    m = {32'd0, modv};
    if (m < 2) return '0;
    e = (act == ActInverse) ? m - 2 : {32'd0, expo};
    // fold the signed base into [0, m)
    sb = longint'(base) % longint'(m);
    if (sb < 0) sb = sb + longint'(m);
    b = longint'(sb);
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc[W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    errors++;
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Present one request, hold it until taken, then queue its expected result
  task automatic send_request(logic act, logic signed [W-1:0] base, logic [W-1:0] expo,
                              logic known, logic [W-1:0] want);
    int           gap;
    logic [W-1:0] queued;
    gap = (quiet_tail || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    base_value_i <= base;
    exponent_i   <= expo;
    do @(posedge clk_i); while (in_stall_o);
    queued = known ? want : predict_power(act, base, expo, cur_modulus);
    expected_results = {expected_results, queued};
  endtask

  // Drop the request valid and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [W-1:0] value);
    cfg_valid_i   <= 1'b1;
    cfg_modulus_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_modulus = value;
  endtask

  // Random request: full-range words, with small values and extremes mixed in
  task automatic send_random_request();
    logic                act;
    logic signed [W-1:0] base;
    logic [W-1:0]        expo;
    act = ($urandom_range(0, 3) == 0) ? ActInverse : ActPower;
    case ($urandom_range(0, 5))
      0: base = $signed(W'($urandom_range(0, 16))) - 8;
      1: base = ($urandom_range(0, 1) != 0) ? BASE_MIN : BASE_MAX;
      2: base = ($urandom_range(0, 1) != 0) ? -1 : 0;
      default: base = $urandom;
    endcase
    case ($urandom_range(0, 6))
      0: expo = '0;
      1: expo = EXP_ONES;
      2: expo = $urandom_range(0, 16);
      default: expo = $urandom;
    endcase
    send_request(act, base, expo, 1'b0, '0);
  endtask

  // Receiver stalls in random bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!quiet_tail && stall_on && $urandom_range(0, 15) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", result_o, '0);
      end else begin
        oldest_result = expected_results.pop_front();
        if (result_o !== oldest_result) report_mismatch("result", result_o, oldest_result);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modular_power_and_inverse_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t    directed_plan[DIRECTED_ROWS];
    logic [W-1:0] phase_modulus[RANDOM_PHASES];
    logic [W-1:0] small_primes[6];

    // set, modulus, action, base, exponent, known, expected
    directed_plan = '{
      // reset modulus
      '{1'b0, '0, ActPower, 32'sd2, 32'd10, 1'b1, 32'd1024},
      '{1'b0, '0, ActPower, 32'sd0, 32'd0, 1'b1, 32'd1},
      '{1'b0, '0, ActPower, -32'sd1, 32'd3, 1'b1, 32'd1000000006},
      '{1'b0, '0, ActPower, BASE_MIN, 32'd1, 1'b0, '0},
      '{1'b0, '0, ActPower, BASE_MAX, EXP_ONES, 1'b0, '0},
      '{1'b0, '0, ActInverse, 32'sd2, 32'd0, 1'b1, 32'd500000004},
      '{1'b0, '0, ActInverse, 32'sd0, EXP_ONES, 1'b1, 32'd0},
      '{1'b0, '0, ActInverse, 32'sd1000000007, 32'd5, 1'b1, 32'd0},
      '{1'b0, '0, ActInverse, -32'sd1, 32'd0, 1'b1, 32'd1000000006},
      // modulus two: the inverse exponent collapses to zero
      '{1'b1, 32'd2, ActInverse, 32'sd5, 32'd9, 1'b1, 32'd1},
      '{1'b0, '0, ActPower, -32'sd3, 32'd7, 1'b1, 32'd1},
      '{1'b0, '0, ActPower, 32'sd4, 32'd5, 1'b1, 32'd0},
      // degenerate moduli give zero for everything
      '{1'b1, 32'd0, ActPower, 32'sd3, 32'd4, 1'b1, 32'd0},
      '{1'b0, '0, ActInverse, 32'sd7, 32'd0, 1'b1, 32'd0},
      '{1'b1, 32'd1, ActPower, 32'sd5, 32'd0, 1'b1, 32'd0},
      // full-width modulus
      '{1'b1, MOD_TOP, ActPower, -32'sd1, 32'd1, 1'b1, 32'd4294967294},
      '{1'b0, '0, ActPower, BASE_MIN, EXP_ONES, 1'b0, '0},
      '{1'b0, '0, ActPower, BASE_MAX, 32'haaaa_aaaa, 1'b0, '0},
      // largest prime in the word
      '{1'b1, PRIME_TOP, ActInverse, BASE_MIN, 32'd0, 1'b0, '0},
      '{1'b0, '0, ActInverse, 32'sd3, EXP_ONES, 1'b0, '0},
      '{1'b0, '0, ActPower, 32'sd12345, 32'd0, 1'b1, 32'd1},
      '{1'b0, '0, ActPower, 32'sd7, 32'd1, 1'b1, 32'd7}
    };

    small_primes = '{32'd3, 32'd5, 32'd7, 32'd13, 32'd251, 32'd65537};
    phase_modulus[0] = MOD_RESET;
    phase_modulus[1] = PRIME_TOP;
    phase_modulus[2] = {1'b1, 31'($urandom)};
    phase_modulus[3] = small_primes[$urandom_range(0, 5)];
    phase_modulus[4] = 32'd2147483647;
    phase_modulus[5] = $urandom_range(2, 1000);
    phase_modulus[6] = $urandom_range(2, 32'hffff_ffff);
    phase_modulus[7] = 32'd998244353;

    // Hold reset at the start, then release it
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].set_mod) begin
        drain_results();
        write_modulus(directed_plan[i].modv);
      end
      send_request(directed_plan[i].act, directed_plan[i].base, directed_plan[i].expo,
                   directed_plan[i].known, directed_plan[i].want);
    end

    // Random phases, one modulus each; the last runs without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      write_modulus(phase_modulus[p]);
      stall_on   = ($urandom_range(0, 3) != 0);
      quiet_tail = (p == RANDOM_PHASES - 1);
      repeat (PER_PHASE) send_random_request();
    end

    // Wait out the last results, then watch for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("modular_power_and_inverse_core: match");
    end else begin
      $display("modular_power_and_inverse_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mpi_pkg.sv
src/modular_power_and_inverse_core.sv
bench/tb.sv
